### src/job_queue_busy_time_tracker_top_defines.svh
// Assertion macros for the job queue busy-time tracker.
// Included by the top level; no other dependencies.
`ifndef JOB_QUEUE_BUSY_TIME_TRACKER_TOP_DEFINES_SVH
`define JOB_QUEUE_BUSY_TIME_TRACKER_TOP_DEFINES_SVH

// generic clocked assertion with an explicit clock and active-low reset
`define JQBT_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block's own clock and reset
`define JQBT_ASSERT(label, prop, msg) \
  `JQBT_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

### src/jqbt_pkg.sv
// Package for the job queue busy-time tracker: widths, reset values, codes.
// No dependencies.
`default_nettype none

package jqbt_pkg;

  localparam int unsigned TIME_WIDTH_DEF  = 48;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned SUM_WIDTH       = 32;
  localparam int unsigned PERIOD_WIDTH    = 32;
  localparam int unsigned APB_DATA_WIDTH  = 32;
  localparam int unsigned APB_ADDR_WIDTH  = 3;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 32'd1000000;

  typedef enum logic [2:0] {
    OP_QUEUED     = 3'd0,
    OP_STARTED    = 3'd1,
    OP_HW_DONE    = 3'd2,
    OP_SOFT_STOP  = 3'd3,
    OP_POWER_DOWN = 3'd4,
    OP_ADD_SUM    = 3'd5,
    OP_RESET_SUM  = 3'd6,
    OP_NOP        = 3'd7
  } opcode_e;

  // register index, taken from paddr above the byte offset
  typedef enum logic [0:0] {
    REG_UPDATE_PERIOD = 1'b0
  } reg_idx_e;

endpackage

`default_nettype wire

### src/jqbt_if.sv
// Valid/ready channel interfaces for the tracker's event input and result output.
// Depends on jqbt_pkg.
`default_nettype none

interface jqbt_in_if #(
  parameter int unsigned TIME_WIDTH = jqbt_pkg::TIME_WIDTH_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [2:0]            opcode;
  logic [TIME_WIDTH-1:0] timestamp;

  modport source (output valid, output opcode, output timestamp, input ready);
  modport sink   (input valid, input opcode, input timestamp, output ready);
endinterface

interface jqbt_out_if #(
  parameter int unsigned TIME_WIDTH  = jqbt_pkg::TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = jqbt_pkg::COUNT_WIDTH_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COUNT_WIDTH-1:0]     waiting_count;
  logic signed [COUNT_WIDTH-1:0]     running_count;
  logic [COUNT_WIDTH-1:0]            pending_inputs;
  logic [jqbt_pkg::SUM_WIDTH-1:0]    pending_sum;
  logic [TIME_WIDTH-1:0]             both_busy_time;
  logic [TIME_WIDTH-1:0]             hw_busy_time;
  logic                              time_updated;

  modport source (output valid, output waiting_count, output running_count,
                  output pending_inputs, output pending_sum, output both_busy_time,
                  output hw_busy_time, output time_updated, input ready);
  modport sink   (input valid, input waiting_count, input running_count,
                  input pending_inputs, input pending_sum, input both_busy_time,
                  input hw_busy_time, input time_updated, output ready);
endinterface

`default_nettype wire

### src/job_queue_busy_time_tracker_top.sv
// Job queue busy-time tracker, top level: event state, busy-time accounting,
// result buffering and the APB register. Depends on jqbt_pkg, jqbt_if and the defines header.
`default_nettype none
`include "job_queue_busy_time_tracker_top_defines.svh"

// The tracker takes one event word per clock while its ready is high and returns
// one result word per event, registered in the output register or skid entry.
// All state (waiting and running job counts, the saturating pending-input
// count and its sum, both busy-time accumulators and the last update time) is
// updated in the accept cycle by a single pass of logic; the longest path is
// the TIME_WIDTH elapsed-time subtract feeding the period compare and the
// accumulator add. Results go to an output register backed by one skid entry,
// so the input keeps accepting while a result waits and stalls only once two
// results are held. Opcode seven is a no-op that just reports the state. The
// update_period register sits at byte address 0 of the APB port; it is meant
// to be written while no events are in flight. pready is tied high.
module job_queue_busy_time_tracker_top #(
  parameter int unsigned TIME_WIDTH  = jqbt_pkg::TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = jqbt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  jqbt_in_if.sink                               in_i,
  jqbt_out_if.source                            out_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [jqbt_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [jqbt_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [jqbt_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);

  localparam int unsigned PW   = jqbt_pkg::PERIOD_WIDTH;
  localparam int unsigned SW   = jqbt_pkg::SUM_WIDTH;
  // compare width for elapsed time against twice the period
  localparam int unsigned CmpW = (TIME_WIDTH > PW + 1) ? TIME_WIDTH : PW + 1;

  typedef logic signed [COUNT_WIDTH-1:0] cnt_t;
  typedef logic signed [COUNT_WIDTH:0]   tot_t;

  localparam cnt_t CntOne  = cnt_t'(1);
  localparam cnt_t CntZero = cnt_t'(0);

  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] waiting_count;
    logic signed [COUNT_WIDTH-1:0] running_count;
    logic [COUNT_WIDTH-1:0]        pending_inputs;
    logic [SW-1:0]                 pending_sum;
    logic [TIME_WIDTH-1:0]         both_busy_time;
    logic [TIME_WIDTH-1:0]         hw_busy_time;
    logic                          time_updated;
  } res_t;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  cnt_t                  waiting_q, waiting_d;
  cnt_t                  running_q, running_d;
  logic [COUNT_WIDTH-1:0] input_q, input_d;
  logic [SW-1:0]         sum_q, sum_d;
  logic [TIME_WIDTH-1:0] both_q, both_d;
  logic [TIME_WIDTH-1:0] hw_q, hw_d;
  logic [TIME_WIDTH-1:0] last_q, last_d;
  logic [PW-1:0]         period_q;

  logic in_fire;
  logic out_fire;
  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  res_t res_d;

  jqbt_pkg::opcode_e op;
  assign op = jqbt_pkg::opcode_e'(in_i.opcode);

  // ---------------------------------------------------------------------------
  // Job-event count updates
  // ---------------------------------------------------------------------------
  cnt_t                   w_new, r_new;
  logic [COUNT_WIDTH-1:0] inp_new;
  logic                   inp_full, inp_empty;

  assign inp_full  = (input_q == {COUNT_WIDTH{1'b1}});
  assign inp_empty = (input_q == '0);

  always_comb begin
    w_new   = waiting_q;
    r_new   = running_q;
    inp_new = input_q;
    unique case (op)
      jqbt_pkg::OP_QUEUED: begin
        w_new   = waiting_q + CntOne;
        inp_new = inp_full ? input_q : input_q + COUNT_WIDTH'(1);
      end
      jqbt_pkg::OP_STARTED: begin
        w_new   = waiting_q - CntOne;
        r_new   = running_q + CntOne;
        inp_new = inp_empty ? input_q : input_q - COUNT_WIDTH'(1);
      end
      jqbt_pkg::OP_HW_DONE: begin
        r_new   = running_q - CntOne;
      end
      jqbt_pkg::OP_SOFT_STOP: begin
        w_new   = waiting_q + CntOne;
        r_new   = running_q - CntOne;
        inp_new = inp_full ? input_q : input_q + COUNT_WIDTH'(1);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Busy-time update decision
  // ---------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] last0;   // last update time after first-use fill
  logic [TIME_WIDTH-1:0] diff;
  logic                  pboth, phw, cboth, chw;
  logic                  act_edge, slow_done, need;
  tot_t                  new_total;
  logic                  neg_total;

  assign last0     = (last_q == '0) ? in_i.timestamp : last_q;
  assign diff      = in_i.timestamp - last0;
  assign pboth     = (waiting_q > CntZero) && (running_q > CntZero);
  assign phw       = (running_q > CntZero);
  assign cboth     = (w_new > CntZero) && (r_new > CntZero);
  assign chw       = (r_new > CntZero);
  assign act_edge  = (pboth != cboth) || (phw != chw);
  // completion with no activity change: update only after a long gap
  assign slow_done = (running_q > r_new) && (CmpW'(diff) > CmpW'({period_q, 1'b0}));
  assign need      = act_edge || slow_done;
  assign new_total = $signed({w_new[COUNT_WIDTH-1], w_new})
                   + $signed({r_new[COUNT_WIDTH-1], r_new});
  assign neg_total = new_total[COUNT_WIDTH];

  // ---------------------------------------------------------------------------
  // Next state and result word
  // ---------------------------------------------------------------------------
  logic upd;

  always_comb begin
    waiting_d = waiting_q;
    running_d = running_q;
    input_d   = input_q;
    sum_d     = sum_q;
    both_d    = both_q;
    hw_d      = hw_q;
    last_d    = last_q;
    upd       = 1'b0;
    unique case (op)
      jqbt_pkg::OP_QUEUED, jqbt_pkg::OP_STARTED,
      jqbt_pkg::OP_HW_DONE, jqbt_pkg::OP_SOFT_STOP: begin
        waiting_d = w_new;
        running_d = r_new;
        input_d   = inp_new;
        last_d    = need ? in_i.timestamp : last0;
        both_d    = (need && pboth) ? both_q + diff : both_q;
        hw_d      = (need && phw) ? hw_q + diff : hw_q;
        upd       = need;
        if (neg_total) begin
          waiting_d = CntZero;
          running_d = CntZero;
          input_d   = '0;
          both_d    = '0;
          hw_d      = '0;
          last_d    = '0;
        end
      end
      jqbt_pkg::OP_POWER_DOWN: begin
        waiting_d = CntZero;
        running_d = CntZero;
        input_d   = '0;
        both_d    = '0;
        hw_d      = '0;
        last_d    = '0;
      end
      jqbt_pkg::OP_ADD_SUM: begin
        sum_d = sum_q + SW'(input_q);
      end
      jqbt_pkg::OP_RESET_SUM: begin
        sum_d  = '0;
        both_d = '0;
        hw_d   = '0;
      end
      jqbt_pkg::OP_NOP: begin
      end
    endcase

    res_d.waiting_count  = waiting_d;
    res_d.running_count  = running_d;
    res_d.pending_inputs = input_d;
    res_d.pending_sum    = sum_d;
    res_d.both_busy_time = both_d;
    res_d.hw_busy_time   = hw_d;
    res_d.time_updated   = upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= CntZero;
      running_q <= CntZero;
      input_q   <= '0;
      sum_q     <= '0;
      both_q    <= '0;
      hw_q      <= '0;
      last_q    <= '0;
    end else if (in_fire) begin
      waiting_q <= waiting_d;
      running_q <= running_d;
      input_q   <= input_d;
      sum_q     <= sum_d;
      both_q    <= both_d;
      hw_q      <= hw_d;
      last_q    <= last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register plus skid entry
  // ---------------------------------------------------------------------------
  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire || !out_valid_q) begin
        out_valid_q <= skid_valid_q || in_fire;
      end
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire && out_valid_q && !out_o.ready) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end
    if (!skid_valid_q && in_fire && out_valid_q && !out_o.ready) begin
      skid_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.waiting_count  = out_q.waiting_count;
  assign out_o.running_count  = out_q.running_count;
  assign out_o.pending_inputs = out_q.pending_inputs;
  assign out_o.pending_sum    = out_q.pending_sum;
  assign out_o.both_busy_time = out_q.both_busy_time;
  assign out_o.hw_busy_time   = out_q.hw_busy_time;
  assign out_o.time_updated   = out_q.time_updated;

  // ---------------------------------------------------------------------------
  // APB register
  // ---------------------------------------------------------------------------
  logic reg_idx;
  logic apb_wr;

  assign reg_idx = paddr[jqbt_pkg::APB_ADDR_WIDTH-1];
  assign apb_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == jqbt_pkg::REG_UPDATE_PERIOD) ? period_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= jqbt_pkg::PERIOD_RESET;
    end else if (apb_wr && (reg_idx == jqbt_pkg::REG_UPDATE_PERIOD)) begin
      period_q <= pwdata[PW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  tot_t state_total;
  logic job_op;     // word is one of the four job events
  logic sum_op;     // word may move the pending sum
  logic pd_fire;
  logic pd_clear;

  assign state_total = $signed({waiting_q[COUNT_WIDTH-1], waiting_q})
                     + $signed({running_q[COUNT_WIDTH-1], running_q});
  assign job_op   = (op == jqbt_pkg::OP_QUEUED) || (op == jqbt_pkg::OP_STARTED)
                 || (op == jqbt_pkg::OP_HW_DONE) || (op == jqbt_pkg::OP_SOFT_STOP);
  assign sum_op   = (op == jqbt_pkg::OP_ADD_SUM) || (op == jqbt_pkg::OP_RESET_SUM);
  assign pd_fire  = in_fire && (op == jqbt_pkg::OP_POWER_DOWN);
  assign pd_clear = (waiting_q == CntZero) && (running_q == CntZero)
                 && (input_q == '0) && (last_q == '0);

  `JQBT_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid held without result")
  `JQBT_ASSERT(a_total_nonneg, !state_total[COUNT_WIDTH], "negative job total kept")
  `JQBT_ASSERT(a_upd_job_only, in_fire && !job_op |-> !upd, "update flagged on non-job op")
  `JQBT_ASSERT(a_power_down_clears, pd_fire |=> pd_clear, "power down left state")
  `JQBT_ASSERT(a_sum_stable, in_fire && !sum_op |=> $stable(sum_q), "pending sum moved")

endmodule

`default_nettype wire

### verif/jqbt_checker.sv
`timescale 1ns / 1ps
// Result checker for the job queue busy-time tracker: watches the event, result and APB
// channels, keeps its own copy of the tracker state and compares every result word.
// Depends on jqbt_pkg and the channel interfaces in jqbt_if.
module jqbt_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  jqbt_in_if                                  evt_i,
  jqbt_out_if                                 res_i,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [jqbt_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [jqbt_pkg::APB_DATA_WIDTH-1:0] pwdata,
  input  logic [jqbt_pkg::APB_DATA_WIDTH-1:0] prdata,
  input  logic                                pready,
  output int unsigned                         fail_count_o,
  output int unsigned                         words_owed_o
);

  localparam int unsigned TW = jqbt_pkg::TIME_WIDTH_DEF;
  localparam int unsigned CW = jqbt_pkg::COUNT_WIDTH_DEF;
  localparam int unsigned SW = jqbt_pkg::SUM_WIDTH;
  localparam int unsigned PW = jqbt_pkg::PERIOD_WIDTH;

  typedef struct packed {
    logic signed [CW-1:0]  waiting;
    logic signed [CW-1:0]  running;
    logic [CW-1:0]         pending;
    logic [SW-1:0]         sum;
    logic [TW-1:0]         both_busy;
    logic [TW-1:0]         hw_busy;
    logic                  updated;
  } tracker_word_t;

  // tracker state as the checker sees it
  logic [PW-1:0]           period_r;
  logic signed [CW-1:0]    waiting_n;
  logic signed [CW-1:0]    running_n;
  logic [CW-1:0]           pending_n;
  logic [SW-1:0]           pending_sum_r;
  logic [TW-1:0]           both_busy_r;
  logic [TW-1:0]           hw_busy_r;
  logic [TW-1:0]           last_stamp_r;

  tracker_word_t owed_q[$];
  tracker_word_t want_w;
  tracker_word_t got_w;
  int unsigned   fails;
  int unsigned   word_idx;

  function automatic void clear_counts();
    waiting_n    = '0;
    running_n    = '0;
    pending_n    = '0;
    both_busy_r  = '0;
    hw_busy_r    = '0;
    last_stamp_r = '0;
  endfunction

  function automatic tracker_word_t apply_event(input jqbt_pkg::opcode_e op,
                                                input logic [TW-1:0] now);
    logic signed [CW-1:0] pw, pr, cw, cr;
    logic [TW-1:0]        elapsed;
    logic                 pboth, phw, cboth, chw, take;
    tracker_word_t        w;
    take = 1'b0;
    if (op <= jqbt_pkg::OP_SOFT_STOP) begin
      if (last_stamp_r == '0) last_stamp_r = now;
      pw = waiting_n;
      pr = running_n;
      case (op)
        jqbt_pkg::OP_QUEUED: begin
          waiting_n = waiting_n + CW'(1);
          if (pending_n != '1) pending_n = pending_n + 1'b1;
        end
        jqbt_pkg::OP_STARTED: begin
          waiting_n = waiting_n - CW'(1);
          running_n = running_n + CW'(1);
          if (pending_n != '0) pending_n = pending_n - 1'b1;
        end
        jqbt_pkg::OP_HW_DONE: begin
          running_n = running_n - CW'(1);
        end
        default: begin
          waiting_n = waiting_n + CW'(1);
          running_n = running_n - CW'(1);
          if (pending_n != '1) pending_n = pending_n + 1'b1;
        end
      endcase
      cw = waiting_n;
      cr = running_n;
      pboth = (pw > 0) && (pr > 0);
      phw   = pr > 0;
      cboth = (cw > 0) && (cr > 0);
      chw   = cr > 0;
      elapsed = now - last_stamp_r;
      // activity edge always updates; a quiet completion only after two periods
      if (pboth != cboth || phw != chw) take = 1'b1;
      else if (pr > cr) take = {1'b0, elapsed} > {period_r, 1'b0};
      if (take) begin
        if (pboth) both_busy_r = both_busy_r + elapsed;
        if (phw) hw_busy_r = hw_busy_r + elapsed;
        last_stamp_r = now;
      end
      if ((int'(cw) + int'(cr)) < 0) clear_counts();
    end else if (op == jqbt_pkg::OP_POWER_DOWN) begin
      clear_counts();
    end else if (op == jqbt_pkg::OP_ADD_SUM) begin
      pending_sum_r = pending_sum_r + SW'(pending_n);
    end else if (op == jqbt_pkg::OP_RESET_SUM) begin
      pending_sum_r = '0;
      both_busy_r   = '0;
      hw_busy_r     = '0;
    end
    w.waiting   = waiting_n;
    w.running   = running_n;
    w.pending   = pending_n;
    w.sum       = pending_sum_r;
    w.both_busy = both_busy_r;
    w.hw_busy   = hw_busy_r;
    w.updated   = take;
    return w;
  endfunction

  function automatic string word_text(input tracker_word_t w);
    return $sformatf("wait=%0d run=%0d pend=%0d sum=%0d both=%0d hw=%0d upd=%0b",
                     w.waiting, w.running, w.pending, w.sum, w.both_busy, w.hw_busy,
                     w.updated);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_counts();
      period_r      = jqbt_pkg::PERIOD_RESET;
      pending_sum_r = '0;
      owed_q.delete();
      fails         = 0;
      word_idx      = 0;
      fail_count_o <= 0;
      words_owed_o <= 0;
    end else begin
      if (evt_i.valid && evt_i.ready) begin
        owed_q.push_back(apply_event(jqbt_pkg::opcode_e'(evt_i.opcode), evt_i.timestamp));
      end
      if (res_i.valid && res_i.ready) begin
        got_w.waiting   = res_i.waiting_count;
        got_w.running   = res_i.running_count;
        got_w.pending   = res_i.pending_inputs;
        got_w.sum       = res_i.pending_sum;
        got_w.both_busy = res_i.both_busy_time;
        got_w.hw_busy   = res_i.hw_busy_time;
        got_w.updated   = res_i.time_updated;
        if (owed_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("word %0d unexpected: %s", word_idx, word_text(got_w));
        end else begin
          want_w = owed_q.pop_front();
          if (got_w !== want_w) begin
            fails++;
            if (fails <= 10) begin
              $display("word %0d exp: %s", word_idx, word_text(want_w));
              $display("word %0d got: %s", word_idx, word_text(got_w));
            end
          end
        end
        word_idx++;
      end
      if (psel && penable && pready &&
          paddr[jqbt_pkg::APB_ADDR_WIDTH-1:2] == jqbt_pkg::REG_UPDATE_PERIOD) begin
        if (pwrite) begin
          period_r = pwdata;
        end else if (prdata !== period_r) begin
          fails++;
          if (fails <= 10) $display("update_period read exp %0d got %0d", period_r, prdata);
        end
      end
      fail_count_o <= fails;
      words_owed_o <= owed_q.size();
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Top of the busy-time tracker testbench: clock, reset, event and APB stimulus, result
// backpressure and the verdict. Depends on jqbt_pkg, jqbt_if, the tracker and jqbt_checker.
module testbench;

  localparam int unsigned TW = jqbt_pkg::TIME_WIDTH_DEF;
  localparam int unsigned AW = jqbt_pkg::APB_ADDR_WIDTH;
  localparam int unsigned DW = jqbt_pkg::APB_DATA_WIDTH;
  localparam logic [AW-1:0] PERIOD_ADDR = {jqbt_pkg::REG_UPDATE_PERIOD, 2'b00};
  // Longest quiet stretch of a correct run is the long receiver hold plus a long
  // sender gap and an APB access; this is many times that.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic pready;
  int unsigned fail_count;
  int unsigned words_owed;

  // stimulus timestamp state, advanced only by next_stamp
  logic [TW-1:0] stamp_ns;

  jqbt_in_if  evt_bus ();
  jqbt_out_if res_bus ();

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  job_queue_busy_time_tracker_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (evt_bus),
    .out_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  jqbt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt_bus),
    .res_i        (res_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .words_owed_o (words_owed)
  );

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Timestamps mostly move forward in small steps, so the two-period test on quiet
  // completions goes both ways; sometimes they jump anywhere in the 48-bit range,
  // drop to zero (looks like "not yet set") or step backwards (huge elapsed time).
  function automatic logic [TW-1:0] next_stamp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) stamp_ns = stamp_ns + $urandom_range(0, 600);
    else if (r < 80) stamp_ns = stamp_ns + $urandom_range(0, 5000000);
    else if (r < 88) stamp_ns = TW'({$urandom, $urandom});
    else if (r < 92) stamp_ns = '0;
    else if (r < 94) stamp_ns = '1;
    else stamp_ns = stamp_ns - $urandom_range(1, 1000);
    return stamp_ns;
  endfunction

  // Job lifecycle ops dominate; queued slightly outweighs completions so the job
  // total wanders around zero and both the busy states and the negative-total
  // clear get hit.
  function automatic jqbt_pkg::opcode_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 26) return jqbt_pkg::OP_QUEUED;
    if (r < 50) return jqbt_pkg::OP_STARTED;
    if (r < 72) return jqbt_pkg::OP_HW_DONE;
    if (r < 82) return jqbt_pkg::OP_SOFT_STOP;
    if (r < 84) return jqbt_pkg::OP_POWER_DOWN;
    if (r < 91) return jqbt_pkg::OP_ADD_SUM;
    if (r < 94) return jqbt_pkg::OP_RESET_SUM;
    return jqbt_pkg::OP_NOP;
  endfunction

  // Offer one event word and hold it until taken. valid stays up when no gap
  // follows, so back-to-back words never see a low/high pair in one step.
  task automatic send_word(input jqbt_pkg::opcode_e op, input logic [TW-1:0] ts,
                           input int unsigned gap);
    evt_bus.valid     <= 1'b1;
    evt_bus.opcode    <= op;
    evt_bus.timestamp <= ts;
    do @(posedge clk_i); while (!evt_bus.ready);
    if (gap != 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Every event yields a result, so idle means nothing owed.
  task automatic drain();
    evt_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (words_owed != 0) @(posedge clk_i);
  endtask

  // Setup phase, access phase, then psel and penable go low before the next transfer.
  task automatic reg_access(input logic wr, input logic [DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PERIOD_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Period changes only with the block idle; the read back is checked too.
  task automatic set_period(input logic [DW-1:0] value);
    drain();
    reg_access(1'b1, value);
    reg_access(1'b0, '0);
  endtask

  task automatic run_random(input int unsigned count);
    jqbt_pkg::opcode_e op;
    logic [TW-1:0]     ts;
    int unsigned       gap;
    for (int unsigned n = 0; n < count; n++) begin
      op  = pick_op();
      ts  = next_stamp();
      // every third block of 40 words goes without sender gaps
      gap = ((n / 40) % 3 == 0) ? 0 : idle_len();
      send_word(op, ts, gap);
    end
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    evt_bus.valid     <= 1'b0;
    evt_bus.opcode    <= jqbt_pkg::OP_NOP;
    evt_bus.timestamp <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    stamp_ns           = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of update_period
    reg_access(1'b0, '0);

    // Directed words at the reset period.
    send_word(jqbt_pkg::OP_NOP,        48'd0, idle_len());       // state right after reset
    send_word(jqbt_pkg::OP_HW_DONE,    48'd100, idle_len());     // negative total clears
    send_word(jqbt_pkg::OP_QUEUED,     48'd0, idle_len());       // zero stamp, still unset
    send_word(jqbt_pkg::OP_QUEUED,     48'd1000, idle_len());    // first use takes stamp
    send_word(jqbt_pkg::OP_STARTED,    48'd2000, idle_len());    // hardware goes busy
    send_word(jqbt_pkg::OP_STARTED,    48'd5000, idle_len());    // both busy edge
    send_word(jqbt_pkg::OP_QUEUED,     48'd6000, idle_len());
    send_word(jqbt_pkg::OP_STARTED,    48'd7000, idle_len());
    send_word(jqbt_pkg::OP_ADD_SUM,    48'd0, idle_len());
    send_word(jqbt_pkg::OP_HW_DONE,    48'd1500000, idle_len()); // quiet, under two periods
    send_word(jqbt_pkg::OP_HW_DONE,    48'd4000000, idle_len()); // quiet, over two periods
    send_word(jqbt_pkg::OP_HW_DONE,    48'd4000100, idle_len()); // hardware goes idle
    send_word(jqbt_pkg::OP_QUEUED,     48'hFFFF_FFFF_FFFF, idle_len());
    send_word(jqbt_pkg::OP_STARTED,    48'd10, idle_len());      // stamp went backwards
    send_word(jqbt_pkg::OP_SOFT_STOP,  48'd20, idle_len());
    send_word(jqbt_pkg::OP_STARTED,    48'd30, idle_len());
    send_word(jqbt_pkg::OP_STARTED,    48'd40, idle_len());      // pending floors at zero
    send_word(jqbt_pkg::OP_ADD_SUM,    48'd0, idle_len());
    send_word(jqbt_pkg::OP_RESET_SUM,  48'd0, idle_len());
    send_word(jqbt_pkg::OP_NOP,        48'hFFFF_FFFF_FFFF, idle_len());
    send_word(jqbt_pkg::OP_SOFT_STOP,  48'h8000_0000_0000, idle_len());
    send_word(jqbt_pkg::OP_POWER_DOWN, 48'd0, idle_len());
    send_word(jqbt_pkg::OP_ADD_SUM,    48'd0, idle_len());

    // Random phases over the period extremes and a small period.
    set_period('0);
    run_random(300);
    set_period('1);
    run_random(200);
    set_period(32'd250);
    run_random(300);

    set_period(jqbt_pkg::PERIOD_RESET);
    run_random(100);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side backpressure: random stalls with stall-free windows, plus one long
  // hold while the sender keeps offering, so the output and skid entry fill and the
  // input has to stall.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned taken;
    int unsigned cycle;
    bit          held;
    stall_left = 0;
    taken      = 0;
    cycle      = 0;
    held       = 1'b0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (res_bus.valid && res_bus.ready) taken++;
      if (stall_left != 0) begin
        stall_left--;
      end else if (!held && taken >= 500) begin
        stall_left = 120;
        held       = 1'b1;
      end else if ((cycle / 200) % 4 != 0 && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      res_bus.ready <= (stall_left == 0);
    end
  end

  // Watchdog: any long stretch with no word moving on either channel is a hang.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
